/* design/hnq_pkg.sv */
// Shared types and constants for the heightmap normal query block.
package hnq_pkg;

    // Field widths
    localparam int SIZE_W   = 9;
    localparam int POS_W    = 8;
    localparam int SAMPLE_W = 16;
    localparam int DIFF_W   = 17;
    localparam int SQ_W     = 32;
    localparam int SUM_W    = 34;
    localparam int QUOT_W   = 31;
    localparam int ROOT_W   = 16;
    localparam int COMP_W   = 16;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 2'd1;

    // Operations
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Squared z component: 512 * 512
    localparam logic [SQ_W-1:0] Z_SQ = 32'd262144;

    typedef struct packed {
        logic                       opcode;
        logic [POS_W-1:0]           column;
        logic [POS_W-1:0]           row;
        logic signed [SAMPLE_W-1:0] height_value;
    } t_in_item;

    typedef struct packed {
        logic signed [COMP_W-1:0] normal_x;
        logic signed [COMP_W-1:0] normal_y;
        logic signed [COMP_W-1:0] normal_z;
    } t_out_item;

endpackage

/* design/hnq_store.sv */
// Height sample memory: one write port, one registered read port.
module hnq_store import hnq_pkg::*; #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic                i_clk,
    input  logic                i_wr_en,
    input  logic [AW-1:0]       i_wr_addr,
    input  logic [SAMPLE_W-1:0] i_wr_data,
    input  logic                i_rd_en,
    input  logic [AW-1:0]       i_rd_addr,
    output logic [SAMPLE_W-1:0] o_rd_data
);

    logic [SAMPLE_W-1:0] r_mem [DEPTH];
    logic [SAMPLE_W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/hnq_norm_lane.sv */
// One normal component: bit-serial divide c^2*2^30/S, then bit-serial root, rounded.
module hnq_norm_lane import hnq_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [SQ_W-1:0]          i_c2,
    input  logic                     i_neg,
    input  logic [SUM_W-1:0]         i_s,
    output logic                     o_done,
    output logic signed [COMP_W-1:0] o_result
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_DIV  = 2'd1;
    localparam logic [1:0] PH_ROOT = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    logic [1:0]        r_phase, n_phase;
    logic [4:0]        r_cnt, n_cnt;
    logic [SUM_W:0]    r_rem, n_rem;
    logic [QUOT_W-1:0] r_q, n_q;
    logic [ROOT_W-1:0] r_t, n_t;
    logic              r_lsb, n_lsb;
    logic              r_neg, n_neg;

    logic [SUM_W:0]    div_shift;
    logic              div_fit;
    logic [ROOT_W-1:0] cand;
    logic [SQ_W-1:0]   cand_sq;
    logic [ROOT_W:0]   mag;

    // Divide step: shift in one numerator bit, subtract when it fits
    assign div_shift = {r_rem[SUM_W-1:0], (r_cnt == 5'd30) ? r_lsb : 1'b0};
    assign div_fit   = div_shift >= {1'b0, i_s};

    // Root step: try the next bit
    assign cand    = r_t | (ROOT_W'(1) << r_cnt[3:0]);
    assign cand_sq = SQ_W'(cand) * SQ_W'(cand);

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_q     = r_q;
        n_t     = r_t;
        n_lsb   = r_lsb;
        n_neg   = r_neg;
        if (i_start) begin
            n_phase = PH_DIV;
            n_cnt   = 5'd30;
            n_rem   = (SUM_W+1)'(i_c2 >> 1);
            n_q     = '0;
            n_lsb   = i_c2[0];
            n_neg   = i_neg;
        end else begin
            unique case (r_phase)
                PH_DIV: begin
                    n_rem = div_fit ? (div_shift - {1'b0, i_s}) : div_shift;
                    n_q   = {r_q[QUOT_W-2:0], div_fit};
                    if (r_cnt == 5'd0) begin
                        n_phase = PH_ROOT;
                        n_cnt   = 5'd15;
                        n_t     = '0;
                    end else begin
                        n_cnt = r_cnt - 5'd1;
                    end
                end
                PH_ROOT: begin
                    if (cand_sq <= {1'b0, r_q}) begin
                        n_t = cand;
                    end
                    if (r_cnt == 5'd0) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_cnt = r_cnt - 5'd1;
                    end
                end
                PH_IDLE, PH_DONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_q   <= n_q;
        r_t   <= n_t;
        r_lsb <= n_lsb;
        r_neg <= n_neg;
    end

    // Round half up on the doubled root
    assign mag      = ({1'b0, r_t} + (ROOT_W+1)'(1)) >> 1;
    assign o_done   = (r_phase == PH_DONE);
    assign o_result = r_neg ? -$signed(mag[COMP_W-1:0]) : $signed(mag[COMP_W-1:0]);

endmodule

/* design/heightmap_normal_query.sv */
// Top level: wrapped heightmap store with unit normal queries.
// The block can take the next beat right after a write beat. A query holds the input
// stalled while it reduces column and row by the map size (one bit per cycle), reads
// the four neighbours through the single read port of the sample memory, forms the
// difference, squares and sum, and runs 31 divide steps and 16 root steps in the
// three component lanes, which run side by side. When the lanes finish, the output
// register is loaded and the block returns to idle, where the next beat is taken.
// A result still held in the output register by a stalled receiver delays the load,
// and the input stall grows by that wait. Sizes above the MAX parameters saturate,
// zero acts as one.
module heightmap_normal_query import hnq_pkg::*; #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SIZE_W-1:0]    i_cfg_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOD  = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_DIFF = 3'd3;
    localparam logic [2:0] S_SQ   = 3'd4;
    localparam logic [2:0] S_SUM  = 3'd5;
    localparam logic [2:0] S_NORM = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]          r_state, n_state;
    logic [SIZE_W-1:0]   r_map_width, r_map_height;
    logic [SIZE_W-1:0]   r_w, r_h;
    logic [POS_W-1:0]    r_col, r_row;
    logic [SIZE_W:0]     r_cm, n_cm, r_rm, n_rm;
    logic [2:0]          r_cnt, n_cnt;
    logic [SAMPLE_W-1:0] r_smp [4];
    logic signed [DIFF_W-1:0] r_dx, r_dy;
    logic [SQ_W-1:0]     r_dx2, r_dy2;
    logic [SUM_W-1:0]    r_s;
    logic                r_out_valid;
    t_out_item           r_out_data;

    logic                in_accept, out_accept, out_load;
    logic [SIZE_W-1:0]   w_eff, h_eff;
    logic [SIZE_W:0]     cm_shift, rm_shift;
    logic [SIZE_W-1:0]   col_m, row_m, left, right, up, down;
    logic [SIZE_W-1:0]   rd_col, rd_row;
    logic [31:0]         wr_full, rd_full;
    logic                wr_in_range;
    logic                rd_en;
    logic [SAMPLE_W-1:0] rd_data;
    logic signed [2*DIFF_W-1:0] dx_sq, dy_sq;
    logic [2:0]          lane_done;
    logic signed [COMP_W-1:0] comp_x, comp_y, comp_z;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_accept  = r_out_valid && !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= 9'd256;
            r_map_height <= 9'd256;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_MAP_WIDTH) begin
                r_map_width <= i_cfg_data;
            end
            if (i_cfg_index == REG_MAP_HEIGHT) begin
                r_map_height <= i_cfg_data;
            end
        end
    end

    // Effective sizes: zero acts as one, saturate at the store size
    always_comb begin
        priority if (r_map_width == '0) w_eff = SIZE_W'(1);
        else if (32'(r_map_width) > 32'(MAX_WIDTH)) w_eff = SIZE_W'(MAX_WIDTH);
        else w_eff = r_map_width;
        priority if (r_map_height == '0) h_eff = SIZE_W'(1);
        else if (32'(r_map_height) > 32'(MAX_HEIGHT)) h_eff = SIZE_W'(MAX_HEIGHT);
        else h_eff = r_map_height;
    end

    // Write address; writes outside the store are dropped
    assign wr_full     = 32'(i_in_data.row) * 32'(MAX_WIDTH) + 32'(i_in_data.column);
    assign wr_in_range = (32'(i_in_data.column) < 32'(MAX_WIDTH)) &&
                         (32'(i_in_data.row) < 32'(MAX_HEIGHT));

    // Remainder steps for column and row
    assign cm_shift = {r_cm[SIZE_W-1:0], r_col[r_cnt]};
    assign rm_shift = {r_rm[SIZE_W-1:0], r_row[r_cnt]};
    assign n_cm = (cm_shift >= {1'b0, r_w}) ? cm_shift - {1'b0, r_w} : cm_shift;
    assign n_rm = (rm_shift >= {1'b0, r_h}) ? rm_shift - {1'b0, r_h} : rm_shift;

    // Wrapped neighbours
    assign col_m = r_cm[SIZE_W-1:0];
    assign row_m = r_rm[SIZE_W-1:0];
    assign left  = (col_m == '0) ? r_w - SIZE_W'(1) : col_m - SIZE_W'(1);
    assign right = ({1'b0, col_m} + 10'd1 >= {1'b0, r_w}) ? '0 : col_m + SIZE_W'(1);
    assign up    = (row_m == '0) ? r_h - SIZE_W'(1) : row_m - SIZE_W'(1);
    assign down  = ({1'b0, row_m} + 10'd1 >= {1'b0, r_h}) ? '0 : row_m + SIZE_W'(1);

    // Read order: right, left, down, up
    always_comb begin
        unique case (r_cnt[1:0])
            2'd0: begin rd_col = right; rd_row = row_m; end
            2'd1: begin rd_col = left;  rd_row = row_m; end
            2'd2: begin rd_col = col_m; rd_row = down;  end
            2'd3: begin rd_col = col_m; rd_row = up;    end
            default: begin rd_col = col_m; rd_row = row_m; end
        endcase
    end
    assign rd_full = 32'(rd_row) * 32'(MAX_WIDTH) + 32'(rd_col);
    assign rd_en   = (r_state == S_READ) && (r_cnt < 3'd4);

    hnq_store #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (in_accept && (i_in_data.opcode == OP_WRITE) && wr_in_range),
        .i_wr_addr(wr_full[AW-1:0]),
        .i_wr_data(i_in_data.height_value),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_full[AW-1:0]),
        .o_rd_data(rd_data)
    );

    // Sequencer
    assign out_load = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept && (i_in_data.opcode == OP_QUERY)) begin
                    n_state = S_MOD;
                    n_cnt   = 3'd7;
                end
            end
            S_MOD: begin
                if (r_cnt == 3'd0) begin
                    n_state = S_READ;
                end else begin
                    n_cnt = r_cnt - 3'd1;
                end
            end
            S_READ: begin
                if (r_cnt == 3'd4) begin
                    n_state = S_DIFF;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            S_DIFF: n_state = S_SQ;
            S_SQ:   n_state = S_SUM;
            S_SUM:  n_state = S_NORM;
            S_NORM: begin
                if (&lane_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Query datapath
    assign dx_sq = r_dx * r_dx;
    assign dy_sq = r_dy * r_dy;

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_col <= i_in_data.column;
            r_row <= i_in_data.row;
            r_w   <= w_eff;
            r_h   <= h_eff;
            r_cm  <= '0;
            r_rm  <= '0;
        end else if (r_state == S_MOD) begin
            r_cm <= n_cm;
            r_rm <= n_rm;
        end
        if ((r_state == S_READ) && (r_cnt != 3'd0)) begin
            r_smp[r_cnt[1:0] - 2'd1] <= rd_data;
        end
        if (r_state == S_DIFF) begin
            r_dx <= DIFF_W'($signed(r_smp[0])) - DIFF_W'($signed(r_smp[1]));
            r_dy <= DIFF_W'($signed(r_smp[2])) - DIFF_W'($signed(r_smp[3]));
        end
        if (r_state == S_SQ) begin
            r_dx2 <= dx_sq[SQ_W-1:0];
            r_dy2 <= dy_sq[SQ_W-1:0];
        end
        if (r_state == S_SUM) begin
            r_s <= SUM_W'(r_dx2) + SUM_W'(r_dy2) + SUM_W'(Z_SQ);
        end
    end

    // Component lanes, started as the sum is registered
    hnq_norm_lane u_lane_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_state == S_SUM),
        .i_c2(r_dx2), .i_neg(r_dx[DIFF_W-1]), .i_s(r_s),
        .o_done(lane_done[0]), .o_result(comp_x)
    );
    hnq_norm_lane u_lane_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_state == S_SUM),
        .i_c2(r_dy2), .i_neg(r_dy[DIFF_W-1]), .i_s(r_s),
        .o_done(lane_done[1]), .o_result(comp_y)
    );
    hnq_norm_lane u_lane_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_state == S_SUM),
        .i_c2(Z_SQ), .i_neg(1'b1), .i_s(r_s),
        .o_done(lane_done[2]), .o_result(comp_z)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (out_accept) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data.normal_x <= comp_x;
            r_out_data.normal_y <= comp_y;
            r_out_data.normal_z <= comp_z;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    a_query_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_in_data.opcode == OP_QUERY)) |=> (r_state == S_MOD))
        else $error("query beat did not start the remainder steps");
    a_reduced_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> ((r_cm < {1'b0, r_w}) && (r_rm < {1'b0, r_h})))
        else $error("reduced position not below map size");
    a_lanes_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NORM) |-> ((lane_done == 3'b000) || (lane_done == 3'b111)))
        else $error("component lanes out of step");
    a_z_negative: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data.normal_z < 0))
        else $error("z component not negative");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> r_out_valid)
        else $error("loaded result lost");
`endif

endmodule

/* tb/heightmap_normal_query_checker.sv */
// Checker for the heightmap normal query block: predicts normals and compares results.
`timescale 1ns / 1ps

module heightmap_normal_query_checker import hnq_pkg::*; #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_in_item             i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out_item            i_out_data,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SIZE_W-1:0]    i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    // Mirror of the block's state
    logic signed [SAMPLE_W-1:0] height_mirror [0:MAX_WIDTH*MAX_HEIGHT-1];
    logic [SIZE_W-1:0]          width_reg;
    logic [SIZE_W-1:0]          height_reg;
    t_out_item                  normals_due [$];
    int                         fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = normals_due.size();

    initial begin
        fail_count = 0;
        width_reg  = 9'd256;
        height_reg = 9'd256;
        for (int k = 0; k < MAX_WIDTH * MAX_HEIGHT; k++) begin
            height_mirror[k] = '0;
        end
    end

    function automatic int span_of(logic [SIZE_W-1:0] reg_val, int limit);
        if (reg_val == 0) return 1;
        if (reg_val > limit) return limit;
        return int'(reg_val);
    endfunction

    // round(a * 2^14 / sqrt(s)), exact via integer search on the squared ratio
    function automatic longint unsigned unit_ratio(longint unsigned a, longint unsigned s);
        longint unsigned num, lo, hi, mid;
        num = (a * a) << 28;
        lo  = 0;
        hi  = 16384;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid * s <= num) lo = mid;
            else hi = mid - 1;
        end
        if ((2 * lo + 1) * (2 * lo + 1) * s <= 4 * num) lo++;
        return lo;
    endfunction

    function automatic logic signed [COMP_W-1:0] q14_component(longint c, longint unsigned s);
        longint unsigned mag;
        mag = unit_ratio(longint'(c < 0 ? -c : c), s);
        return (c < 0) ? -mag[COMP_W-1:0] : mag[COMP_W-1:0];
    endfunction

    function automatic t_out_item surface_normal(int col, int row);
        int        w, h, lc, rc, ur, dr;
        longint    dx, dy;
        longint unsigned s;
        t_out_item n;
        w  = span_of(width_reg, MAX_WIDTH);
        h  = span_of(height_reg, MAX_HEIGHT);
        col = col % w;
        row = row % h;
        lc = (col == 0) ? w - 1 : col - 1;
        rc = (col + 1 >= w) ? 0 : col + 1;
        ur = (row == 0) ? h - 1 : row - 1;
        dr = (row + 1 >= h) ? 0 : row + 1;
        dx = longint'(height_mirror[row * MAX_WIDTH + rc])
           - longint'(height_mirror[row * MAX_WIDTH + lc]);
        dy = longint'(height_mirror[dr * MAX_WIDTH + col])
           - longint'(height_mirror[ur * MAX_WIDTH + col]);
        s  = longint'(dx * dx + dy * dy) + 262144;
        n.normal_x = q14_component(dx, s);
        n.normal_y = q14_component(dy, s);
        n.normal_z = q14_component(-512, s);
        return n;
    endfunction

    function automatic void flag_mismatch(string what, int exp_v, int act_v);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t mismatch %s: expected %0d, got %0d", $realtime, what, exp_v, act_v);
        end
    endfunction

    // Watch all three channels at each edge
    always @(posedge i_clk) begin
        t_out_item due;
        if (i_rst_n) begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_MAP_WIDTH:  width_reg  = i_cfg_data;
                    REG_MAP_HEIGHT: height_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_data.opcode == OP_WRITE) begin
                    height_mirror[int'(i_in_data.row) * MAX_WIDTH + int'(i_in_data.column)] =
                        i_in_data.height_value;
                end else begin
                    normals_due.push_back(surface_normal(int'(i_in_data.column),
                                                         int'(i_in_data.row)));
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (normals_due.size() == 0) begin
                    flag_mismatch("unexpected beat, normal_x", 0, i_out_data.normal_x);
                end else begin
                    due = normals_due.pop_front();
                    if (due.normal_x !== i_out_data.normal_x)
                        flag_mismatch("normal_x", due.normal_x, i_out_data.normal_x);
                    if (due.normal_y !== i_out_data.normal_y)
                        flag_mismatch("normal_y", due.normal_y, i_out_data.normal_y);
                    if (due.normal_z !== i_out_data.normal_z)
                        flag_mismatch("normal_z", due.normal_z, i_out_data.normal_z);
                end
            end
        end
    end

endmodule

/* tb/heightmap_normal_query_tb.sv */
// Testbench top for the heightmap normal query block: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module heightmap_normal_query_tb;
    import hnq_pkg::*;

    localparam int MAP_MAX = 256;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [SIZE_W-1:0]    i_cfg_data = '0;
    int                   fail_count;
    int                   pending;

    // Stimulus-side view of the map
    bit                   sample_known [0:MAP_MAX*MAP_MAX-1];
    logic [SIZE_W-1:0]    cur_width = 9'd256;
    logic [SIZE_W-1:0]    cur_height = 9'd256;
    bit                   no_gaps = 1'b0;
    bit                   hold_req = 1'b0;
    bit                   hold_done = 1'b0;

    always #2 i_clk = ~i_clk;

    heightmap_normal_query #(.MAX_WIDTH(MAP_MAX), .MAX_HEIGHT(MAP_MAX)) u_dut (.*);

    heightmap_normal_query_checker #(.MAX_WIDTH(MAP_MAX), .MAX_HEIGHT(MAP_MAX)) u_checker (
        .i_clk, .i_rst_n,
        .i_in_valid, .i_in_stall(o_in_stall), .i_in_data,
        .i_out_valid(o_out_valid), .i_out_stall, .i_out_data(o_out_data),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic int span_of(logic [SIZE_W-1:0] reg_val);
        if (reg_val == 0) return 1;
        if (reg_val > MAP_MAX) return MAP_MAX;
        return int'(reg_val);
    endfunction

    // One input beat, with a random gap in front of it
    task automatic send_beat(logic op, int col, int row, logic [SAMPLE_W-1:0] hv);
        int r, gap;
        r   = $urandom_range(0, 99);
        gap = no_gaps ? 0 : (r < 50) ? 0 : (r < 92) ? $urandom_range(1, 3)
                                                    : $urandom_range(10, 40);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid             <= 1'b1;
        i_in_data.opcode       <= op;
        i_in_data.column       <= col[POS_W-1:0];
        i_in_data.row          <= row[POS_W-1:0];
        i_in_data.height_value <= hv;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (op == OP_WRITE) sample_known[row * MAP_MAX + col] = 1'b1;
    endtask

    task automatic write_sample(int col, int row, logic [SAMPLE_W-1:0] hv);
        send_beat(OP_WRITE, col, row, hv);
    endtask

    // Make sure the four neighbours hold data before querying
    task automatic query_normal(int col, int row);
        int w, h, c, rw;
        int nc [4];
        int nr [4];
        w  = span_of(cur_width);
        h  = span_of(cur_height);
        c  = col % w;
        rw = row % h;
        nc = '{(c == 0) ? w - 1 : c - 1, (c + 1 >= w) ? 0 : c + 1, c, c};
        nr = '{rw, rw, (rw == 0) ? h - 1 : rw - 1, (rw + 1 >= h) ? 0 : rw + 1};
        for (int k = 0; k < 4; k++) begin
            if (!sample_known[nr[k] * MAP_MAX + nc[k]])
                write_sample(nc[k], nr[k], SAMPLE_W'($urandom));
        end
        send_beat(OP_QUERY, col, row, SAMPLE_W'($urandom));
    endtask

    // Drain everything, then let the block settle before touching registers
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_MAP_WIDTH) cur_width = val;
        if (idx == REG_MAP_HEIGHT) cur_height = val;
    endtask

    task automatic random_items(int count);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < 65)
                query_normal($urandom_range(0, 255), $urandom_range(0, 255));
            else
                write_sample($urandom_range(0, 255), $urandom_range(0, 255),
                             SAMPLE_W'($urandom));
        end
    endtask

    // Receiver stalls, with one long hold-off on request
    initial begin
        forever begin
            if (hold_req && !hold_done) begin
                i_out_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                hold_done = 1'b1;
            end else if ($urandom_range(0, 99) < 30) begin
                i_out_stall <= 1'b1;
                repeat (($urandom_range(0, 99) < 8) ? $urandom_range(20, 80)
                                                    : $urandom_range(1, 3)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end
        end
    end

    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extreme differences at the wrapped corner, full-size map
        write_sample(1, 0, 16'sh7fff);
        write_sample(255, 0, 16'sh8000);
        write_sample(0, 1, 16'sh8000);
        write_sample(0, 255, 16'sh7fff);
        query_normal(0, 0);
        write_sample(254, 255, 16'sh8000);
        write_sample(0, 255, 16'sh7fff);
        write_sample(255, 0, 16'sh7fff);
        write_sample(255, 254, 16'sh8000);
        query_normal(255, 255);
        write_sample(11, 10, 16'sh0000);
        write_sample(9, 10, 16'sh0000);
        write_sample(10, 11, 16'sh0000);
        write_sample(10, 9, 16'sh0000);
        query_normal(10, 10);
        write_sample(11, 10, 16'sh0001);
        query_normal(10, 10);
        query_normal(128, 77);

        // Random part with a long receiver hold-off in the middle
        random_items(12);
        hold_req = 1'b1;
        random_items(30);

        // Single column and row, both by one and by zero
        wait_idle();
        write_reg(REG_MAP_WIDTH, 9'd1);
        write_reg(REG_MAP_HEIGHT, 9'd1);
        query_normal(0, 0);
        query_normal(200, 99);
        random_items(16);
        wait_idle();
        write_reg(REG_MAP_WIDTH, 9'd0);
        write_reg(REG_MAP_HEIGHT, 9'd0);
        write_reg(2'd2, 9'd5);
        write_reg(2'd3, 9'h1ff);
        no_gaps = 1'b1;
        random_items(16);

        // Oversized width saturates; short map
        wait_idle();
        no_gaps = 1'b0;
        write_reg(REG_MAP_WIDTH, 9'h1ff);
        write_reg(REG_MAP_HEIGHT, 9'd3);
        random_items(20);

        // Narrow tall map
        wait_idle();
        write_reg(REG_MAP_WIDTH, 9'd7);
        write_reg(REG_MAP_HEIGHT, 9'h1ff);
        random_items(20);

        // Tiny map, then back to the full map
        wait_idle();
        write_reg(REG_MAP_WIDTH, 9'd2);
        write_reg(REG_MAP_HEIGHT, 9'd2);
        random_items(14);
        wait_idle();
        write_reg(REG_MAP_WIDTH, 9'd256);
        write_reg(REG_MAP_HEIGHT, 9'd256);
        random_items(16);

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
